FILE: hw/rtl/ihex_enc_pkg.sv
package ihex_enc_pkg;

    localparam int WORDS_PER_RECORD = 4;

    // word count held in the buffer, 0 .. WORDS_PER_RECORD
    localparam int CNT_W = $clog2(WORDS_PER_RECORD + 1);
    localparam int IDX_W = (WORDS_PER_RECORD > 1) ? $clog2(WORDS_PER_RECORD) : 1;
    // byte position inside a record: count, address, type, payload, checksum
    localparam int POS_W = $clog2(4 * WORDS_PER_RECORD + 6);
    localparam int WIDX_W = 14;

    localparam logic [31:0] BASE_RESET = 32'h2001_0000;

    localparam logic [1:0] MODE_WORD  = 2'd0;
    localparam logic [1:0] MODE_FLUSH = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam logic [7:0] REC_DATA      = 8'h00;
    localparam logic [7:0] REC_EOF       = 8'h01;
    localparam logic [7:0] REC_EXT_LIN   = 8'h04;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;

    typedef enum logic [2:0] {
        CH_COLON,
        CH_HI,
        CH_LO,
        CH_CR,
        CH_LF
    } char_sel_t;

    typedef struct packed {
        logic      step;
        char_sel_t sel;
        logic      is_sum;
    } char_ctrl_t;

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/intel_hex_record_encoder_core.sv
// Intel HEX encoder: each input word carries a 32-bit code word in tdata and a mode in
// tuser (0 data word, 1 flush partial record, 2 end of file, 3 ignored). The text comes
// out one ASCII character per output word, tlast marking the last character an input
// word caused. A character sequencer feeds one shared hex/checksum unit, so one character
// is produced per cycle while m_tready is high: a buffered data word with no record due
// produces no text, the word that fills a four-word record its 45-character data record,
// the first data word of a file first brings out the 17-character type 04 record, and end
// of file 34 characters (17 more if no type 04 record went out before).
// s_tready stays low while a record is being emitted. The user writes base_address
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce this.
module intel_hex_record_encoder_core
    import ihex_enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // code_word
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // ascii_char
    output logic        m_tlast    // last_char
);

    typedef enum logic [1:0] {
        K_HDR,
        K_DATA,
        K_START,
        K_EOF
    } kind_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_COLON,
        P_HI,
        P_LO,
        P_CR,
        P_LF
    } phase_t;

    logic [31:0] word_buffer [WORDS_PER_RECORD];

    phase_t             phase_reg, phase_next;
    kind_t              kind_reg, kind_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WIDX_W-1:0]  idx_reg, idx_next;
    logic               hdr_sent_reg, hdr_sent_next;
    logic               pend_data_reg, pend_data_next;
    logic               pend_end_reg, pend_end_next;
    logic [31:0]        base_reg, base_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    logic               in_fire;
    logic               buf_we;
    logic               emit;
    logic [POS_W-1:0]   plen;
    logic [POS_W-1:0]   sum_pos;
    logic [POS_W-1:0]   k;
    logic [15:0]        addr;
    logic [31:0]        sel_word;
    logic [7:0]         field_byte;
    logic [7:0]         ascii_char;
    logic [CNT_W-1:0]   count_inc;
    logic               full;
    logic               has_next;
    kind_t              next_kind;
    char_ctrl_t         ctrl;

    assign s_tready = (phase_reg == P_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign emit     = (phase_reg != P_IDLE) && (!m_valid_reg || m_tready);
    assign buf_we   = in_fire && (s_tuser == MODE_WORD);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            word_buffer[count_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    // payload length in bytes of the record under way
    always_comb
    begin
        unique case (kind_reg)
            K_HDR:   plen = POS_W'(2);
            K_DATA:  plen = POS_W'({count_reg, 2'b00});
            K_START: plen = POS_W'(4);
            K_EOF:   plen = '0;
            default: plen = '0;
        endcase
    end

    assign sum_pos  = POS_W'(4) + plen;
    assign k        = pos_reg - POS_W'(4);
    assign addr     = base_reg[15:0] + {idx_reg, 2'b00};
    assign sel_word = word_buffer[k[IDX_W+1:2]];

    always_comb
    begin
        priority if (pos_reg == POS_W'(0))
        begin
            unique case (kind_reg)
                K_HDR:   field_byte = 8'h02;
                K_DATA:  field_byte = 8'({count_reg, 2'b00});
                K_START: field_byte = 8'h04;
                default: field_byte = 8'h00;
            endcase
        end
        else if (pos_reg == POS_W'(1))
        begin
            field_byte = (kind_reg == K_DATA) ? addr[15:8] : 8'h00;
        end
        else if (pos_reg == POS_W'(2))
        begin
            field_byte = (kind_reg == K_DATA) ? addr[7:0] : 8'h00;
        end
        else if (pos_reg == POS_W'(3))
        begin
            unique case (kind_reg)
                K_HDR:   field_byte = REC_EXT_LIN;
                K_DATA:  field_byte = REC_DATA;
                K_START: field_byte = REC_START_LIN;
                default: field_byte = REC_EOF;
            endcase
        end
        else if (kind_reg == K_DATA)
        begin
            // data bytes go out least significant first
            unique case (k[1:0])
                2'd0:    field_byte = sel_word[7:0];
                2'd1:    field_byte = sel_word[15:8];
                2'd2:    field_byte = sel_word[23:16];
                default: field_byte = sel_word[31:24];
            endcase
        end
        else
        begin
            // address records carry the base most significant first
            unique case (k[1:0])
                2'd0:    field_byte = base_reg[31:24];
                2'd1:    field_byte = base_reg[23:16];
                2'd2:    field_byte = base_reg[15:8];
                default: field_byte = base_reg[7:0];
            endcase
        end
    end

    always_comb
    begin
        ctrl.step   = emit;
        ctrl.is_sum = (pos_reg == sum_pos);
        unique case (phase_reg)
            P_COLON: ctrl.sel = CH_COLON;
            P_HI:    ctrl.sel = CH_HI;
            P_LO:    ctrl.sel = CH_LO;
            P_CR:    ctrl.sel = CH_CR;
            default: ctrl.sel = CH_LF;
        endcase
    end

    ihex_enc_char_unit u_char
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .field_byte (field_byte),
        .ascii_char (ascii_char)
    );

    // which record follows the one that just ended
    always_comb
    begin
        has_next  = 1'b0;
        next_kind = K_DATA;
        unique case (kind_reg)
            K_HDR:
            begin
                if (pend_data_reg)
                begin
                    has_next  = 1'b1;
                    next_kind = K_DATA;
                end
                else if (pend_end_reg)
                begin
                    has_next  = 1'b1;
                    next_kind = K_START;
                end
            end
            K_START:
            begin
                has_next  = 1'b1;
                next_kind = K_EOF;
            end
            default:
            begin
                has_next = 1'b0;
            end
        endcase
    end

    assign count_inc = count_reg + CNT_W'(1);
    assign full      = (count_inc == CNT_W'(WORDS_PER_RECORD));

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        hdr_sent_next  = hdr_sent_reg;
        pend_data_next = pend_data_reg;
        pend_end_next  = pend_end_reg;
        base_next      = cfg_we ? cfg_wdata : base_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            unique case (s_tuser)
                MODE_WORD:
                begin
                    count_next = count_inc;
                    if (!hdr_sent_reg || full)
                    begin
                        phase_next     = P_COLON;
                        pos_next       = '0;
                        kind_next      = hdr_sent_reg ? K_DATA : K_HDR;
                        pend_data_next = full;
                        pend_end_next  = 1'b0;
                        hdr_sent_next  = 1'b1;
                    end
                end
                MODE_FLUSH:
                begin
                    if (count_reg != '0)
                    begin
                        phase_next     = P_COLON;
                        pos_next       = '0;
                        kind_next      = hdr_sent_reg ? K_DATA : K_HDR;
                        pend_data_next = 1'b1;
                        pend_end_next  = 1'b0;
                        hdr_sent_next  = 1'b1;
                    end
                end
                MODE_END:
                begin
                    // buffered words are dropped and the file state starts over
                    phase_next     = P_COLON;
                    pos_next       = '0;
                    kind_next      = hdr_sent_reg ? K_START : K_HDR;
                    pend_data_next = 1'b0;
                    pend_end_next  = 1'b1;
                    hdr_sent_next  = 1'b0;
                    count_next     = '0;
                    idx_next       = '0;
                end
                default:
                begin
                    phase_next = P_IDLE;
                end
            endcase
        end

        if (emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = ascii_char;
            m_last_next  = 1'b0;
            unique case (phase_reg)
                P_COLON:
                begin
                    phase_next = P_HI;
                end
                P_HI:
                begin
                    phase_next = P_LO;
                end
                P_LO:
                begin
                    if (pos_reg == sum_pos)
                    begin
                        phase_next = P_CR;
                    end
                    else
                    begin
                        phase_next = P_HI;
                        pos_next   = pos_reg + POS_W'(1);
                    end
                end
                P_CR:
                begin
                    phase_next = P_LF;
                end
                default:
                begin
                    if (kind_reg == K_DATA)
                    begin
                        idx_next       = idx_reg + WIDX_W'(count_reg);
                        count_next     = '0;
                        pend_data_next = 1'b0;
                    end
                    pos_next = '0;
                    if (has_next)
                    begin
                        phase_next = P_COLON;
                        kind_next  = next_kind;
                    end
                    else
                    begin
                        phase_next     = P_IDLE;
                        pend_data_next = 1'b0;
                        pend_end_next  = 1'b0;
                        m_last_next    = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            kind_reg      <= K_HDR;
            pos_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            hdr_sent_reg  <= 1'b0;
            pend_data_reg <= 1'b0;
            pend_end_reg  <= 1'b0;
            base_reg      <= BASE_RESET;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= 8'd0;
            m_last_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            hdr_sent_reg  <= hdr_sent_next;
            pend_data_reg <= pend_data_next;
            pend_end_reg  <= pend_end_next;
            base_reg      <= base_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            m_last_reg    <= m_last_next;
        end
    end

endmodule

FILE: hw/rtl/ihex_enc_char_unit.sv
module ihex_enc_char_unit
    import ihex_enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  char_ctrl_t ctrl,
    input  logic [7:0] field_byte,
    output logic [7:0] ascii_char
);

    logic [7:0] checksum_reg;
    logic [7:0] checksum_next;
    logic [7:0] byte_val;

    // the checksum field is the two's complement of the running byte sum
    assign byte_val = ctrl.is_sum ? (8'd0 - checksum_reg) : field_byte;

    always_comb
    begin
        unique case (ctrl.sel)
            CH_COLON: ascii_char = ASCII_COLON;
            CH_HI:    ascii_char = hex_char(byte_val[7:4]);
            CH_LO:    ascii_char = hex_char(byte_val[3:0]);
            CH_CR:    ascii_char = ASCII_CR;
            CH_LF:    ascii_char = ASCII_LF;
            default:  ascii_char = ASCII_LF;
        endcase
    end

    // the sum is held across the checksum field so both its digits see it
    always_comb
    begin
        checksum_next = checksum_reg;
        if (ctrl.step)
        begin
            if (ctrl.sel == CH_COLON)
            begin
                checksum_next = 8'd0;
            end
            else if ((ctrl.sel == CH_HI) && !ctrl.is_sum)
            begin
                checksum_next = checksum_reg + byte_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checksum_reg <= 8'd0;
        end
        else
        begin
            checksum_reg <= checksum_next;
        end
    end

endmodule

FILE: sim/ihex_text_checker.sv
`timescale 1ns / 100ps

module ihex_text_checker
    import ihex_enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending_chars
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    // own copy of the encoder state
    logic [31:0]      base_addr;
    logic [31:0]      held_words [WORDS_PER_RECORD];
    int               held_count;
    logic [WIDX_W-1:0] rec_index;
    logic             ela_sent;
    logic [7:0]       rec_sum;

    logic [7:0]       item_text[$];
    text_char_t       text_due[$];
    int               mismatch_total = 0;

    assign mismatches = mismatch_total;

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] nib);
        if (nib > 4'd9)
        begin
            return 8'h41 + 8'(nib - 4'd10);
        end
        return 8'h30 + 8'(nib);
    endfunction

    task automatic put_char(input logic [7:0] c);
        item_text = {item_text, c};
    endtask

    task automatic put_hex_byte(input logic [7:0] b);
        rec_sum = rec_sum + b;
        put_char(nibble_to_ascii(b[7:4]));
        put_char(nibble_to_ascii(b[3:0]));
    endtask

    task automatic open_record(input logic [7:0] len, input logic [15:0] addr,
                               input logic [7:0] rtype);
        rec_sum = 8'd0;
        put_char(ASCII_COLON);
        put_hex_byte(len);
        put_hex_byte(addr[15:8]);
        put_hex_byte(addr[7:0]);
        put_hex_byte(rtype);
    endtask

    task automatic close_record();
        logic [7:0] sum;
        sum = 8'd0 - rec_sum;
        put_hex_byte(sum);
        put_char(ASCII_CR);
        put_char(ASCII_LF);
    endtask

    task automatic emit_ext_linear();
        open_record(8'd2, 16'd0, REC_EXT_LIN);
        put_hex_byte(base_addr[31:24]);
        put_hex_byte(base_addr[23:16]);
        close_record();
        ela_sent = 1'b1;
    endtask

    task automatic emit_data_record();
        logic [31:0] addr;
        logic [31:0] w;
        addr = base_addr + {16'd0, rec_index, 2'b00};
        open_record(8'(held_count * 4), addr[15:0], REC_DATA);
        for (int i = 0; i < held_count; i++)
        begin
            w = held_words[i];
            put_hex_byte(w[7:0]);
            put_hex_byte(w[15:8]);
            put_hex_byte(w[23:16]);
            put_hex_byte(w[31:24]);
        end
        close_record();
        rec_index = rec_index + WIDX_W'(held_count);
        held_count = 0;
    endtask

    task automatic clear_file();
        held_count = 0;
        rec_index = '0;
        ela_sent = 1'b0;
        rec_sum = 8'd0;
    endtask

    task automatic predict_item(input logic [1:0] mode, input logic [31:0] word);
        text_char_t entry;
        item_text.delete();
        case (mode)
            MODE_WORD:
            begin
                if (!ela_sent)
                begin
                    emit_ext_linear();
                end
                if (held_count < WORDS_PER_RECORD)
                begin
                    held_words[held_count] = word;
                    held_count++;
                end
                if (held_count >= WORDS_PER_RECORD)
                begin
                    emit_data_record();
                end
            end
            MODE_FLUSH:
            begin
                if (held_count > 0)
                begin
                    if (!ela_sent)
                    begin
                        emit_ext_linear();
                    end
                    emit_data_record();
                end
            end
            MODE_END:
            begin
                // words still held are dropped, start address then eof
                if (!ela_sent)
                begin
                    emit_ext_linear();
                end
                open_record(8'd4, 16'd0, REC_START_LIN);
                put_hex_byte(base_addr[31:24]);
                put_hex_byte(base_addr[23:16]);
                put_hex_byte(base_addr[15:8]);
                put_hex_byte(base_addr[7:0]);
                close_record();
                open_record(8'd0, 16'd0, REC_EOF);
                close_record();
                clear_file();
            end
            default:
            begin
                // unused mode, no text
            end
        endcase
        for (int i = 0; i < item_text.size(); i++)
        begin
            entry.ch = item_text[i];
            entry.last = (i == item_text.size() - 1);
            text_due = {text_due, entry};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        text_char_t got;
        if (!rst_n)
        begin
            base_addr = BASE_RESET;
            clear_file();
            text_due.delete();
            pending_chars <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_addr = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                predict_item(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (text_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char %02h last %0b",
                                              m_tdata, m_tlast));
                end
                else
                begin
                    got = text_due.pop_front();
                    if (m_tdata !== got.ch)
                    begin
                        report_mismatch($sformatf("char %02h, expected %02h",
                                                  m_tdata, got.ch));
                    end
                    if (m_tlast !== got.last)
                    begin
                        report_mismatch($sformatf("tlast %0b, expected %0b on char %02h",
                                                  m_tlast, got.last, got.ch));
                    end
                end
            end
            pending_chars <= text_due.size();
        end
    end

endmodule

FILE: sim/intel_hex_record_encoder_core_tb.sv
`timescale 1ns / 100ps

module intel_hex_record_encoder_core_tb;
    import ihex_enc_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int PHASES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // code_word
    logic [1:0]  s_tuser = '0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // ascii_char
    logic        m_tlast;        // last_char

    int mismatches;
    int pending_chars;
    int src_idle_pct = 26;
    int dst_idle_pct = 62;

    intel_hex_record_encoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    ihex_text_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending_chars (pending_chars)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // valid stays high across back-to-back words
    task automatic send_item(input logic [1:0] mode, input logic [31:0] word);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= word;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_text();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_chars != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_base(input logic [31:0] value);
        drain_text();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] bases [PHASES];
        logic [1:0]  mode;
        int          sent;
        int          r;

        bases[0] = BASE_RESET;
        bases[1] = 32'h0000_0000;
        bases[2] = 32'hFFFF_FFFF;
        bases[3] = 32'h0000_FFF0;
        bases[4] = $urandom;
        bases[5] = $urandom;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset base
        send_item(MODE_SPARE, 32'hFFFF_FFFF);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_END,   32'h0000_0000);
        send_item(MODE_WORD,  32'h0000_0000);
        send_item(MODE_WORD,  32'hFFFF_FFFF);
        send_item(MODE_WORD,  32'h1234_5678);
        send_item(MODE_WORD,  32'h8000_0001);
        send_item(MODE_WORD,  32'hA5A5_A5A5);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_FLUSH, 32'hFFFF_FFFF);
        send_item(MODE_WORD,  32'hDEAD_BEEF);
        send_item(MODE_WORD,  32'h0123_4567);
        send_item(MODE_WORD,  32'hFEDC_BA98);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_WORD,  32'h0000_FFFF);
        send_item(MODE_SPARE, 32'h0000_0000);
        send_item(MODE_WORD,  32'hFFFF_0000);
        send_item(MODE_END,   32'hFFFF_FFFF);
        send_item(MODE_END,   32'h0000_0000);
        send_item(MODE_WORD,  32'h7FFF_FFFF);
        send_item(MODE_FLUSH, 32'h0000_0000);
        send_item(MODE_END,   32'h0000_0000);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 2)
            begin
                src_idle_pct = 62;
                dst_idle_pct = 26;
            end
            else if (phase == 4)
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            if (phase > 0)
            begin
                write_base(bases[phase]);
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (sent == ITEMS_PER_PHASE / 2)
                begin
                    drain_text();
                end
                r = $urandom_range(99);
                if (r < 70)
                begin
                    mode = MODE_WORD;
                end
                else if (r < 82)
                begin
                    mode = MODE_FLUSH;
                end
                else if (r < 93)
                begin
                    mode = MODE_END;
                end
                else
                begin
                    mode = MODE_SPARE;
                end
                send_item(mode, pick_word());
                if (mode != MODE_SPARE)
                begin
                    sent++;
                end
            end
        end

        drain_text();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_chars == 0)
        begin
            $display("intel_hex_record_encoder_core_tb: PASS");
        end
        else
        begin
            $display("intel_hex_record_encoder_core_tb: FAIL");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("intel_hex_record_encoder_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ihex_enc_pkg.sv
hw/rtl/ihex_enc_char_unit.sv
hw/rtl/intel_hex_record_encoder_core.sv
sim/ihex_text_checker.sv
sim/intel_hex_record_encoder_core_tb.sv
